// File: src/gcd_pkg.sv
package gcd_pkg;

    localparam int ROT_W       = 33;
    localparam int PROD_W      = 2 * ROT_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int DP_W        = 32;
    localparam int SQRT_W      = 62;
    localparam int SQRT_STEPS  = 31;
    localparam int VEC_W       = 34;
    localparam int RAD_W       = 16;
    localparam int ARC_W       = 26;
    localparam int T_W         = 32;

    localparam longint START_GAIN_Q30 = 64'sd652032874;
    localparam longint Q30_ONE        = 64'sd1073741824;
    localparam logic [30:0] RAD_PER_DEG_Q36 = 31'd1199381129;
    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd3959;
    localparam logic [ARC_W-1:0] ARC_MAX = '1;

    localparam longint ATAN_DEG_Q24 [32] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234683,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7, 4, 2, 1, 0
    };

    function automatic longint step_angle(input int k, input int f);
        longint t;
        int     sh;
        t  = ATAN_DEG_Q24[k & 31];
        sh = 24 - f;
        if (f >= 24) begin
            return t <<< (f - 24);
        end
        return (t + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

endpackage

// File: src/gcd_cordic_cell.sv
module gcd_cordic_cell #(
    parameter int STEP   = 0,
    parameter int FRAC   = 16,
    parameter int XW     = 33,
    parameter int ZW     = 26,
    parameter int TW     = 1,
    parameter bit VECTOR = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic [TW-1:0]        i_tag,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [TW-1:0]        o_tag
);

    localparam logic signed [ZW-1:0] ANGLE = ZW'(gcd_pkg::step_angle(STEP, FRAC));

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 dir;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [TW-1:0]        r_tag;

    assign dx  = i_y >>> STEP;
    assign dy  = i_x >>> STEP;
    assign dir = VECTOR ? (i_y >= 0) : (i_z >= 0);

    always_comb begin
        if (dir ^ VECTOR) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ANGLE;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_tag = r_tag;

endmodule

// File: src/gcd_sqrt_cell.sv
module gcd_sqrt_cell #(
    parameter int STEP = 0,
    parameter int NW   = 62,
    parameter int TW   = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_n,
    input  logic [NW-1:0] i_r,
    input  logic [TW-1:0] i_tag,
    output logic [NW-1:0] o_n,
    output logic [NW-1:0] o_r,
    output logic [TW-1:0] o_tag
);

    localparam logic [NW-1:0] BITV = NW'(1) << (60 - 2 * STEP);

    logic [NW-1:0] trial;
    logic [NW-1:0] n_n;
    logic [NW-1:0] n_r;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_r;
    logic [TW-1:0] r_tag;

    assign trial = i_r + BITV;

    always_comb begin
        if (i_n >= trial) begin
            n_n = i_n - trial;
            n_r = (i_r >> 1) + BITV;
        end else begin
            n_n = i_n;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= n_n;
            r_r   <= n_r;
            r_tag <= i_tag;
        end
    end

    assign o_n   = r_n;
    assign o_r   = r_r;
    assign o_tag = r_tag;

endmodule

// File: src/great_circle_distance.sv
// Channel   Dir  Word                                          Bits
// s_axis    in   lat_a, lon_a, lat_b, lon_b                    104
// m_axis    out  arc_length                                    32
// cfg       in   sphere_radius, write only                     16
// One word is accepted per cycle while s_axis_tready is high; results leave in input order.
// The pipeline runs through the two CORDIC cell rows and the 31-cell square root row.
// Reset is synchronous and active low; it clears the valid chain and sets the radius.
// When a result waits at the output, the pipeline still moves while its last stage is empty.
module great_circle_distance #(
    parameter int CORDIC_STEPS    = 20,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // lat_a, lon_a, lat_b, lon_b, zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // arc_length, zero fill
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata
);

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int ZW    = F + 10;
    localparam int S     = CORDIC_STEPS;
    localparam int LAT   = 2 * S + 41;
    localparam int SHL   = (F >= 16) ? F - 16 : 0;
    localparam int SHR   = (F >= 16) ? 0 : 16 - F;
    localparam int RW    = gcd_pkg::ROT_W;
    localparam int VW    = gcd_pkg::VEC_W;
    localparam int NW    = gcd_pkg::SQRT_W;
    localparam int DW    = gcd_pkg::DP_W;
    localparam int PW    = gcd_pkg::PROD_W;
    localparam int SW    = gcd_pkg::SUM_W;
    localparam int M1W   = ZW + 30;
    localparam int M2W   = gcd_pkg::T_W + gcd_pkg::RAD_W;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(longint'(90) <<< F);
    localparam logic signed [ZW-1:0] HALF    = ZW'(longint'(180) <<< F);
    localparam logic signed [ZW-1:0] FULL    = ZW'(longint'(360) <<< F);
    localparam logic [M1W-1:0] M1_RND = M1W'(1) << (F + 7);
    localparam logic [M2W-1:0] M2_RND = M2W'(1) << 19;

    logic                  adv;
    logic [LAT-1:0]        r_valid;
    logic                  r_out_valid;
    logic [gcd_pkg::ARC_W-1:0] r_out;
    logic [gcd_pkg::RAD_W-1:0] r_radius;

    logic signed [24:0]    raw [4];
    logic signed [RW-1:0]  rx [4][S+1];
    logic signed [RW-1:0]  ry [4][S+1];
    logic signed [ZW-1:0]  rz [4][S+1];
    logic                  rt [4][S+1];
    logic signed [RW-1:0]  r_c [4];
    logic signed [RW-1:0]  r_s [4];

    assign adv           = !r_valid[LAT-1] || !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv;

    assign raw[0] = 25'($signed(s_axis_tdata[23:0]));
    assign raw[1] = $signed(s_axis_tdata[48:24]);
    assign raw[2] = 25'($signed(s_axis_tdata[72:49]));
    assign raw[3] = $signed(s_axis_tdata[97:73]);

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic signed [48:0]   wide;
        logic signed [ZW-1:0] ang;
        logic signed [ZW-1:0] wrp;
        logic signed [ZW-1:0] n_z0;
        logic                 n_neg;
        logic signed [ZW-1:0] r_z0;
        logic                 r_neg;

        always_comb begin
            wide = (49'(raw[l]) <<< SHL) >>> SHR;
            ang  = ZW'(wide);
            if (ang >= HALF) begin
                wrp = ang - FULL;
            end else if (ang < -HALF) begin
                wrp = ang + FULL;
            end else begin
                wrp = ang;
            end
            if (wrp > QUARTER) begin
                n_z0  = wrp - HALF;
                n_neg = 1'b1;
            end else if (wrp < -QUARTER) begin
                n_z0  = wrp + HALF;
                n_neg = 1'b1;
            end else begin
                n_z0  = wrp;
                n_neg = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_z0  <= n_z0;
                r_neg <= n_neg;
            end
        end

        assign rx[l][0] = RW'(gcd_pkg::START_GAIN_Q30);
        assign ry[l][0] = '0;
        assign rz[l][0] = r_z0;
        assign rt[l][0] = r_neg;

        for (genvar k = 0; k < S; k++) begin : g_cell
            gcd_cordic_cell #(
                .STEP(k), .FRAC(F), .XW(RW), .ZW(ZW), .TW(1), .VECTOR(1'b0)
            ) u_cell (
                .i_clk(i_clk), .i_en(adv),
                .i_x(rx[l][k]), .i_y(ry[l][k]), .i_z(rz[l][k]), .i_tag(rt[l][k]),
                .o_x(rx[l][k+1]), .o_y(ry[l][k+1]), .o_z(rz[l][k+1]),
                .o_tag(rt[l][k+1])
            );
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_c[l] <= rt[l][S] ? -rx[l][S] : rx[l][S];
                r_s[l] <= rt[l][S] ? -ry[l][S] : ry[l][S];
            end
        end
    end

    logic signed [PW-1:0] r_p0a, r_p1a, r_p0b, r_p1b;
    logic signed [RW-1:0] r_za, r_zb;
    logic signed [RW-1:0] va0, va1, vb0, vb1;
    logic signed [PW-1:0] r_d0, r_d1, r_d2;
    logic signed [SW-1:0] dsum;
    logic signed [SW-31:0] dsh;
    logic signed [DW-1:0] n_dp;
    logic signed [DW-1:0] r_dp, r_dp_q, r_dp_n;
    logic signed [2*DW-1:0] r_sq;
    logic [NW-1:0]        r_n0;

    assign va0 = RW'(r_p0a >>> 30);
    assign va1 = RW'(r_p1a >>> 30);
    assign vb0 = RW'(r_p0b >>> 30);
    assign vb1 = RW'(r_p1b >>> 30);
    assign dsum = SW'(r_d0) + SW'(r_d1) + SW'(r_d2);
    assign dsh  = (SW-30)'(dsum >>> 30);

    always_comb begin
        if (dsh > (SW-30)'(gcd_pkg::Q30_ONE)) begin
            n_dp = DW'(gcd_pkg::Q30_ONE);
        end else if (dsh < -(SW-30)'(gcd_pkg::Q30_ONE)) begin
            n_dp = -DW'(gcd_pkg::Q30_ONE);
        end else begin
            n_dp = DW'(dsh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p0a  <= r_c[1] * r_c[0];
            r_p1a  <= r_s[1] * r_c[0];
            r_za   <= r_s[0];
            r_p0b  <= r_c[3] * r_c[2];
            r_p1b  <= r_s[3] * r_c[2];
            r_zb   <= r_s[2];
            r_d0   <= va0 * vb0;
            r_d1   <= va1 * vb1;
            r_d2   <= r_za * r_zb;
            r_dp   <= n_dp;
            r_sq   <= r_dp * r_dp;
            r_dp_q <= r_dp;
            r_n0   <= (NW'(1) << 60) - NW'(r_sq[60:0]);
            r_dp_n <= r_dp_q;
        end
    end

    logic [NW-1:0] sn [gcd_pkg::SQRT_STEPS+1];
    logic [NW-1:0] sr [gcd_pkg::SQRT_STEPS+1];
    logic [DW-1:0] st [gcd_pkg::SQRT_STEPS+1];

    assign sn[0] = r_n0;
    assign sr[0] = '0;
    assign st[0] = r_dp_n;

    for (genvar k = 0; k < gcd_pkg::SQRT_STEPS; k++) begin : g_sqrt
        gcd_sqrt_cell #(.STEP(k), .NW(NW), .TW(DW)) u_cell (
            .i_clk(i_clk), .i_en(adv),
            .i_n(sn[k]), .i_r(sr[k]), .i_tag(st[k]),
            .o_n(sn[k+1]), .o_r(sr[k+1]), .o_tag(st[k+1])
        );
    end

    logic signed [VW-1:0] sroot;
    logic signed [DW-1:0] dpv;
    logic signed [VW-1:0] vx [S+1];
    logic signed [VW-1:0] vy [S+1];
    logic signed [ZW-1:0] vz [S+1];
    logic                 vt [S+1];
    logic signed [VW-1:0] r_vx0, r_vy0;
    logic signed [ZW-1:0] r_vz0;

    assign sroot = VW'($signed({1'b0, sr[gcd_pkg::SQRT_STEPS][30:0]}));
    assign dpv   = $signed(st[gcd_pkg::SQRT_STEPS]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (dpv < 0) begin
                r_vx0 <= sroot;
                r_vy0 <= -VW'(dpv);
                r_vz0 <= QUARTER;
            end else begin
                r_vx0 <= VW'(dpv);
                r_vy0 <= sroot;
                r_vz0 <= '0;
            end
        end
    end

    assign vx[0] = r_vx0;
    assign vy[0] = r_vy0;
    assign vz[0] = r_vz0;
    assign vt[0] = 1'b0;

    for (genvar k = 0; k < S; k++) begin : g_vec
        gcd_cordic_cell #(
            .STEP(k), .FRAC(F), .XW(VW), .ZW(ZW), .TW(1), .VECTOR(1'b1)
        ) u_cell (
            .i_clk(i_clk), .i_en(adv),
            .i_x(vx[k]), .i_y(vy[k]), .i_z(vz[k]), .i_tag(vt[k]),
            .o_x(vx[k+1]), .o_y(vy[k+1]), .o_z(vz[k+1]), .o_tag(vt[k+1])
        );
    end

    logic [ZW-2:0]    zc;
    logic [M1W-1:0]   r_m1;
    logic [M1W-1:0]   m1r;
    logic [gcd_pkg::T_W-1:0] tval;
    logic [M2W-1:0]   r_m2;
    logic [M2W-1:0]   m2r;
    logic [28:0]      dval;

    assign zc   = (vz[S] < 0 || vt[S]) ? '0 : vz[S][ZW-2:0];
    assign m1r  = r_m1 + M1_RND;
    assign tval = gcd_pkg::T_W'(m1r >> (F + 8));
    assign m2r  = r_m2 + M2_RND;
    assign dval = 29'(m2r >> 20);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1 <= M1W'(zc) * M1W'(gcd_pkg::RAD_PER_DEG_Q36);
            r_m2 <= M2W'(tval) * M2W'(r_radius);
        end
        if (adv && r_valid[LAT-1]) begin
            r_out <= (dval > 29'(gcd_pkg::ARC_MAX)) ? gcd_pkg::ARC_MAX
                                                    : gcd_pkg::ARC_W'(dval);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_radius    <= gcd_pkg::RADIUS_RESET;
        end else begin
            if (adv) begin
                r_valid <= {r_valid[LAT-2:0], s_axis_tvalid};
            end
            if (adv && r_valid[LAT-1]) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out};

`ifndef NO_ASSERTIONS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_valid[0])
        else $error("accepted word did not enter the pipeline");
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_valid))
        else $error("pipeline moved while stalled");
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_valid[LAT-1] |=> r_out_valid)
        else $error("finished word not loaded into output register");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !(adv && r_valid[LAT-1]))
        else $error("waiting result would be overwritten");
`endif

endmodule
